### design/arc_pkg.sv
// Shared types, microcode program and constants of the address range cache.
`default_nettype none

package arc_pkg;

  // One cache entry as it sits in the entry memory.
  typedef struct packed {
    logic [31:0] count;
    logic [31:0] last;
    logic [31:0] hi;
    logic [31:0] lo;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef logic [3:0] upc_t;

  // Datapath action selected by one control word.
  typedef enum logic [2:0] {
    U_NOP     = 3'd0,
    U_WAIT    = 3'd1,
    U_FIND    = 3'd2,
    U_HIT_END = 3'd3,
    U_MIN     = 3'd4,
    U_STORE   = 3'd5,
    U_EMIT    = 3'd6
  } uop_e;

  // Jump condition; a true condition loads the target, else the step counter advances.
  typedef enum logic [2:0] {
    C_ALWAYS      = 3'd0,
    C_NO_XFER     = 3'd1,
    C_INSERT      = 3'd2,
    C_FIND_MORE   = 3'd3,
    C_EMPTY_RANGE = 3'd4,
    C_HAS_ROOM    = 3'd5,
    C_MIN_MORE    = 3'd6,
    C_OUT_FREE    = 3'd7
  } cond_e;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  target;
  } ucode_t;

  // Program addresses.
  localparam upc_t UPC_WAIT     = 4'd0;
  localparam upc_t UPC_DECODE   = 4'd1;
  localparam upc_t UPC_FIND     = 4'd2;
  localparam upc_t UPC_HIT_END  = 4'd3;
  localparam upc_t UPC_INSERT   = 4'd4;
  localparam upc_t UPC_ROOM     = 4'd5;
  localparam upc_t UPC_MIN      = 4'd6;
  localparam upc_t UPC_STORE    = 4'd7;
  localparam upc_t UPC_EMIT     = 4'd8;
  localparam upc_t UPC_EMIT_RET = 4'd9;

  function automatic ucode_t ucode(input upc_t pc);
    ucode_t w;
    case (pc)
      UPC_WAIT:     w = '{uop: U_WAIT,    cond: C_NO_XFER,     target: UPC_WAIT};
      UPC_DECODE:   w = '{uop: U_NOP,     cond: C_INSERT,      target: UPC_INSERT};
      UPC_FIND:     w = '{uop: U_FIND,    cond: C_FIND_MORE,   target: UPC_FIND};
      UPC_HIT_END:  w = '{uop: U_HIT_END, cond: C_ALWAYS,      target: UPC_EMIT};
      UPC_INSERT:   w = '{uop: U_NOP,     cond: C_EMPTY_RANGE, target: UPC_EMIT};
      UPC_ROOM:     w = '{uop: U_NOP,     cond: C_HAS_ROOM,    target: UPC_STORE};
      UPC_MIN:      w = '{uop: U_MIN,     cond: C_MIN_MORE,    target: UPC_MIN};
      UPC_STORE:    w = '{uop: U_STORE,   cond: C_ALWAYS,      target: UPC_EMIT};
      UPC_EMIT:     w = '{uop: U_EMIT,    cond: C_OUT_FREE,    target: UPC_WAIT};
      UPC_EMIT_RET: w = '{uop: U_NOP,     cond: C_ALWAYS,      target: UPC_EMIT};
      default:      w = '{uop: U_NOP,     cond: C_ALWAYS,      target: UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/arc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module arc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/address_range_cache_lfu.sv
// Address range cache with least-frequently-used replacement, microcoded control.
//
// Holds up to ENTRIES address ranges in one entry memory that is read one entry per
// cycle. An item with tuser = 0 looks its address up: filled entries are scanned from
// index 0, and the first one whose last-hit address equals the address or whose
// inclusive [lower, upper] range holds it hits; its count rises (saturating) and its
// bounds return with found = 1. An item with tuser = 1 inserts a range: an empty range
// (lower equal to upper) is dropped with an all-zero result, otherwise the range is
// appended while there is room, or else it replaces the lowest-index entry among those
// with the smallest hit count; stored = 1 and slot name the entry written. Exactly one
// result follows each item. A lookup scans the filled entries up to the first hit and a
// replacement scans all ENTRIES of them, both through the single read port of the entry
// memory, one entry per cycle. One item is worked at a time; the next is taken while a
// finished result waits in the output register.
`default_nettype none

module address_range_cache_lfu #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // addr, lower_in, upper_in
  input  wire logic [0:0]  s_axis_tuser,   // op
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // lower_out, upper_out, slot, zero pad
  output logic [1:0]       m_axis_tuser    // found, stored
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  arc_pkg::upc_t   upc_q, upc_d;
  arc_pkg::ucode_t uc;
  logic            jump;

  logic          op_q;
  logic [31:0]   addr_q, lo_q, hi_q;
  logic [CW-1:0] idx_q, fill_q, limit;
  logic          cmp_vld_q, hit_q;
  logic [IW-1:0] cmp_idx_q, hit_idx_q, best_idx_q, store_idx;
  logic [31:0]   best_cnt_q;
  arc_pkg::entry_t ent_q;

  logic          res_found_q, res_stored_q;
  logic [31:0]   res_lo_q, res_hi_q;
  logic [3:0]    res_slot_q;

  logic          out_vld_q, out_found_q, out_stored_q;
  logic [31:0]   out_lo_q, out_hi_q;
  logic [3:0]    out_slot_q;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr, ram_raddr;
  arc_pkg::entry_t ram_wdata, ram_rdata;

  logic xfer_in, out_free, rd_issue, scan_done, addr_hit, has_room;

  assign uc = arc_pkg::ucode(upc_q);

  assign s_axis_tready = (uc.uop == arc_pkg::U_WAIT);
  assign xfer_in       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  assign limit     = (uc.uop == arc_pkg::U_MIN) ? CW'(ENTRIES) : fill_q;
  assign rd_issue  = idx_q < limit;
  assign scan_done = !cmp_vld_q && !rd_issue;
  assign has_room  = fill_q < CW'(ENTRIES);
  assign store_idx = has_room ? fill_q[IW-1:0] : best_idx_q;
  assign addr_hit  = cmp_vld_q && ((ram_rdata.last == addr_q) ||
                     ((ram_rdata.lo <= addr_q) && (addr_q <= ram_rdata.hi)));

  always_comb begin
    case (uc.cond)
      arc_pkg::C_ALWAYS:      jump = 1'b1;
      arc_pkg::C_NO_XFER:     jump = !s_axis_tvalid;
      arc_pkg::C_INSERT:      jump = op_q;
      arc_pkg::C_FIND_MORE:   jump = !(addr_hit || scan_done);
      arc_pkg::C_EMPTY_RANGE: jump = (lo_q == hi_q);
      arc_pkg::C_HAS_ROOM:    jump = has_room;
      arc_pkg::C_MIN_MORE:    jump = !scan_done;
      arc_pkg::C_OUT_FREE:    jump = out_free;
      default:                jump = 1'b1;
    endcase
    upc_d = jump ? uc.target : upc_q + 4'd1;
  end

  // Entry memory write: count bump on a hit, fresh entry on a store.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = ent_q;
    ram_wdata.count = (ent_q.count == '1) ? ent_q.count : ent_q.count + 32'd1;
    ram_wdata.last  = addr_q;
    case (uc.uop)
      arc_pkg::U_HIT_END: ram_we = hit_q;
      arc_pkg::U_STORE: begin
        ram_we    = 1'b1;
        ram_waddr = store_idx;
        ram_wdata = '{count: 32'd0, last: addr_q, hi: hi_q, lo: lo_q};
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign ram_raddr = idx_q[IW-1:0];

  arc_ram #(
    .WIDTH (arc_pkg::EntryW),
    .DEPTH (ENTRIES)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q     <= arc_pkg::UPC_WAIT;
      fill_q    <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (xfer_in) begin
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end
      if ((uc.uop == arc_pkg::U_FIND) || (uc.uop == arc_pkg::U_MIN)) begin
        cmp_vld_q <= rd_issue;
      end
      if ((uc.uop == arc_pkg::U_FIND) && addr_hit) begin
        hit_q <= 1'b1;
      end
      if ((uc.uop == arc_pkg::U_STORE) && has_room) begin
        fill_q <= fill_q + CW'(1);
      end
      if ((uc.uop == arc_pkg::U_EMIT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_in) begin
      op_q         <= s_axis_tuser[0];
      addr_q       <= s_axis_tdata[31:0];
      lo_q         <= s_axis_tdata[63:32];
      hi_q         <= s_axis_tdata[95:64];
      idx_q        <= '0;
      res_found_q  <= 1'b0;
      res_stored_q <= 1'b0;
      res_lo_q     <= '0;
      res_hi_q     <= '0;
      res_slot_q   <= '0;
    end
    if ((uc.uop == arc_pkg::U_FIND) || (uc.uop == arc_pkg::U_MIN)) begin
      if (rd_issue) begin
        idx_q <= idx_q + CW'(1);
      end
      cmp_idx_q <= idx_q[IW-1:0];
    end
    // Hold the first hit; the read port moves on to the next entry.
    if ((uc.uop == arc_pkg::U_FIND) && addr_hit) begin
      ent_q     <= ram_rdata;
      hit_idx_q <= cmp_idx_q;
    end
    if ((uc.uop == arc_pkg::U_MIN) && cmp_vld_q &&
        ((cmp_idx_q == '0) || (ram_rdata.count < best_cnt_q))) begin
      best_cnt_q <= ram_rdata.count;
      best_idx_q <= cmp_idx_q;
    end
    if ((uc.uop == arc_pkg::U_HIT_END) && hit_q) begin
      res_found_q <= 1'b1;
      res_lo_q    <= ent_q.lo;
      res_hi_q    <= ent_q.hi;
      res_slot_q  <= 4'(hit_idx_q);
    end
    if (uc.uop == arc_pkg::U_STORE) begin
      res_stored_q <= 1'b1;
      res_slot_q   <= 4'(store_idx);
    end
    if ((uc.uop == arc_pkg::U_EMIT) && out_free) begin
      out_found_q  <= res_found_q;
      out_stored_q <= res_stored_q;
      out_lo_q     <= res_lo_q;
      out_hi_q     <= res_hi_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_slot_q, out_hi_q, out_lo_q};
  assign m_axis_tuser  = {out_stored_q, out_found_q};

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer_in |=> !s_axis_tready)
    else $error("input taken again before the current item finished");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(ENTRIES))
    else $error("fill count beyond entry count");

  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both hit and store");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((uc.uop == arc_pkg::U_STORE) && has_room) |=> (fill_q != '0))
    else $error("append did not advance the fill count");

endmodule

`default_nettype wire
